// File: rtl/core/bgc_pkg.sv
// Shared types and constants for the button gesture classifier.
`timescale 1ns / 1ps

package bgc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned TogglesW = 2;

  localparam logic [CfgW-1:0] LongPressRst    = 16'd3000;
  localparam logic [CfgW-1:0] MinPressRst     = 16'd40;
  localparam logic [CfgW-1:0] DoubleWindowRst = 16'd350;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_PRESS    = 2'd0,
    CFG_MIN_PRESS     = 2'd1,
    CFG_DOUBLE_WINDOW = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic             button_down;
    logic [TimeW-1:0] now_ms;
    logic             alarm_overlay_active;
    logic             double_press_mode;
  } sample_t;

  typedef struct packed {
    logic                go_to_sleep;
    logic                stop_alarm;
    logic                toggle_fullscreen;
    logic [TogglesW-1:0] screen_toggles;
  } result_t;

endpackage

// File: rtl/core/bgc_if.sv
// Sample and result channel interfaces of the button gesture classifier.
`timescale 1ns / 1ps

interface bgc_sample_if;
  logic        valid;
  logic        ready;
  logic        button_down;
  logic [31:0] now_ms;
  logic        alarm_overlay_active;
  logic        double_press_mode;

  modport source (
    output valid, button_down, now_ms, alarm_overlay_active, double_press_mode,
    input  ready
  );
  modport sink (
    input  valid, button_down, now_ms, alarm_overlay_active, double_press_mode,
    output ready
  );
endinterface

interface bgc_result_if;
  logic       valid;
  logic       ready;
  logic       go_to_sleep;
  logic       stop_alarm;
  logic       toggle_fullscreen;
  logic [1:0] screen_toggles;

  modport source (
    output valid, go_to_sleep, stop_alarm, toggle_fullscreen, screen_toggles,
    input  ready
  );
  modport sink (
    input  valid, go_to_sleep, stop_alarm, toggle_fullscreen, screen_toggles,
    output ready
  );
endinterface

// File: rtl/core/bgc_in_stage.sv
// Input register: captures one sample beat.
`timescale 1ns / 1ps

module bgc_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bgc_pkg::sample_t  in_data_i,
  output logic              valid_o,      // valid towards the next stage
  input  logic              next_ready_i,
  output bgc_pkg::sample_t  data_o
);

  logic             valid_q, valid_d;
  bgc_pkg::sample_t data_q;
  logic             take;

  // Accept while empty or while the held beat moves on
  assign in_ready_o = !valid_q || next_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (next_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/core/bgc_classify.sv
// Gesture state, configuration registers and classification logic.
`timescale 1ns / 1ps

module bgc_classify (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bgc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [bgc_pkg::CfgW-1:0]            cfg_wdata_i,
  input  logic                                advance_i,   // sample consumed this cycle
  input  bgc_pkg::sample_t                    sample_i,
  output bgc_pkg::result_t                    result_o
);

  logic [bgc_pkg::CfgW-1:0]  long_q, min_q, dwin_q;
  logic                      prev_q, prev_d;
  logic [bgc_pkg::TimeW-1:0] start_q, start_d;
  logic                      long_done_q, long_done_d;
  logic [bgc_pkg::TimeW-1:0] last_rel_q, last_rel_d;
  logic                      pend_q, pend_d;
  logic [bgc_pkg::TimeW-1:0] pend_at_q, pend_at_d;

  logic                      down, rise, fall, long_eff, sleep, short_ok;
  logic                      dpath, in_win, full, defer, imm, pend1, fire;
  logic [bgc_pkg::TimeW-1:0] held, since_rel, since_pend, now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q <= bgc_pkg::LongPressRst;
      min_q  <= bgc_pkg::MinPressRst;
      dwin_q <= bgc_pkg::DoubleWindowRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bgc_pkg::CFG_LONG_PRESS:    long_q <= cfg_wdata_i;
        bgc_pkg::CFG_MIN_PRESS:     min_q  <= cfg_wdata_i;
        bgc_pkg::CFG_DOUBLE_WINDOW: dwin_q <= cfg_wdata_i;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  always_comb begin
    now   = sample_i.now_ms;
    down  = sample_i.button_down;
    rise  = down && !prev_q;
    fall  = !down && prev_q;

    // A new press restarts the hold timer
    start_d  = rise ? now : start_q;
    long_eff = rise ? 1'b0 : long_done_q;
    held     = now - start_d;

    sleep       = down && !long_eff && (held >= {16'd0, long_q});
    long_done_d = long_eff || sleep;

    short_ok = fall && !long_eff && (held >= {16'd0, min_q}) && (held < {16'd0, long_q});

    since_rel = now - last_rel_q;
    in_win    = since_rel < {16'd0, dwin_q};
    dpath     = short_ok && !sample_i.alarm_overlay_active && sample_i.double_press_mode;
    full      = dpath && in_win;
    defer     = dpath && !in_win;
    imm       = short_ok && !sample_i.alarm_overlay_active && !sample_i.double_press_mode;

    last_rel_d = full ? '0 : (defer ? now : last_rel_q);
    pend_at_d  = defer ? now : pend_at_q;
    pend1      = full ? 1'b0 : (defer ? 1'b1 : (pend_q && !sleep));

    since_pend = now - pend_at_d;
    fire       = pend1 && (since_pend >= {16'd0, dwin_q});
    pend_d     = pend1 && !fire;
    prev_d     = down;

    result_o.go_to_sleep       = sleep;
    result_o.stop_alarm        = short_ok && sample_i.alarm_overlay_active;
    result_o.toggle_fullscreen = full;
    result_o.screen_toggles    = {1'b0, imm} + {1'b0, fire};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= 1'b0;
      start_q     <= '0;
      long_done_q <= 1'b0;
      last_rel_q  <= '0;
      pend_q      <= 1'b0;
      pend_at_q   <= '0;
    end else if (advance_i) begin
      prev_q      <= prev_d;
      start_q     <= start_d;
      long_done_q <= long_done_d;
      last_rel_q  <= last_rel_d;
      pend_q      <= pend_d;
      pend_at_q   <= pend_at_d;
    end
  end

endmodule

// File: rtl/core/bgc_out_stage.sv
// Result register: holds one result beat until the sink takes it.
`timescale 1ns / 1ps

module bgc_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               up_valid_i,
  output logic               up_ready_o,
  input  bgc_pkg::result_t   data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bgc_pkg::result_t   data_o
);

  logic             valid_q, valid_d;
  bgc_pkg::result_t data_q;
  logic             load;

  assign up_ready_o = !valid_q || out_ready_i;
  assign load       = up_valid_i && up_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign data_o      = data_q;

endmodule

// File: rtl/core/button_gesture_classifier.sv
// Button gesture classifier: short, long and double press detection.
// A sample sits in the input register, then its result in the result register.
// Throughput: one sample per cycle while results are taken; the classification
// is one pass of compare logic between the input register and the result register.
// Reset: asynchronous, active low; clears gesture state and loads default timings.
`timescale 1ns / 1ps

module button_gesture_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bgc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bgc_pkg::CfgW-1:0]    cfg_wdata_i,
  bgc_sample_if.sink                  in_if,
  bgc_result_if.source                out_if
);

  bgc_pkg::sample_t   in_data, stage_data;
  bgc_pkg::result_t   res_d, res_q;
  logic               stage_valid;
  logic               out_up_ready;
  logic               in_ready;

  assign in_data.button_down          = in_if.button_down;
  assign in_data.now_ms               = in_if.now_ms;
  assign in_data.alarm_overlay_active = in_if.alarm_overlay_active;
  assign in_data.double_press_mode    = in_if.double_press_mode;
  assign in_if.ready                  = in_ready;

  bgc_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_o   (in_ready),
    .in_data_i    (in_data),
    .valid_o      (stage_valid),
    .next_ready_i (out_up_ready),
    .data_o       (stage_data)
  );

  bgc_classify u_cls (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (stage_valid && out_up_ready),
    .sample_i    (stage_data),
    .result_o    (res_d)
  );

  bgc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .up_valid_i  (stage_valid),
    .up_ready_o  (out_up_ready),
    .data_i      (res_d),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .data_o      (res_q)
  );

  assign out_if.go_to_sleep       = res_q.go_to_sleep;
  assign out_if.stop_alarm        = res_q.stop_alarm;
  assign out_if.toggle_fullscreen = res_q.toggle_fullscreen;
  assign out_if.screen_toggles    = res_q.screen_toggles;

endmodule

// File: rtl/core/bgc_checker.sv
// Port-level checks for the button gesture classifier, bound to the top level.
`timescale 1ns / 1ps

module bgc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       go_to_sleep_i,
  input logic       stop_alarm_i,
  input logic       toggle_fullscreen_i,
  input logic [1:0] screen_toggles_i
);

  // A beat carries at most one of the exclusive gesture events
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot0({go_to_sleep_i, stop_alarm_i, toggle_fullscreen_i}))
    else $error("exclusive gesture events raised together");

  a_toggle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (screen_toggles_i != 2'd3))
    else $error("screen toggle count out of range");

  // Two toggles need an immediate one, which excludes every other event
  a_double_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && screen_toggles_i == 2'd2) |->
      (!stop_alarm_i && !toggle_fullscreen_i && !go_to_sleep_i))
    else $error("double toggle beside another event");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable({go_to_sleep_i, stop_alarm_i, toggle_fullscreen_i,
                               screen_toggles_i})))
    else $error("stalled result beat changed");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_i         (out_if.valid),
  .out_ready_i         (out_if.ready),
  .go_to_sleep_i       (out_if.go_to_sleep),
  .stop_alarm_i        (out_if.stop_alarm),
  .toggle_fullscreen_i (out_if.toggle_fullscreen),
  .screen_toggles_i    (out_if.screen_toggles)
);

// File: test/button_gesture_classifier_tb.sv
// Self-checking testbench for the button gesture classifier: gesture stimulus and event checks.
`timescale 1ns / 1ps

module button_gesture_classifier_tb;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [bgc_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [bgc_pkg::CfgW-1:0] cfg_wdata_i;

  bgc_sample_if smp_if ();
  bgc_result_if res_if ();

  button_gesture_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (smp_if),
    .out_if      (res_if)
  );

  // Timing registers as the block should hold them
  logic [bgc_pkg::CfgW-1:0] long_ms   = bgc_pkg::LongPressRst;
  logic [bgc_pkg::CfgW-1:0] min_ms    = bgc_pkg::MinPressRst;
  logic [bgc_pkg::CfgW-1:0] window_ms = bgc_pkg::DoubleWindowRst;

  // Gesture state of the predictor
  logic        prev_down   = 1'b0;
  logic [31:0] press_t0    = '0;
  logic        long_fired  = 1'b0;
  logic [31:0] last_rel_t  = '0;
  logic        single_wait = 1'b0;
  logic [31:0] single_t0   = '0;

  bgc_pkg::sample_t pending_samples[$];
  bgc_pkg::result_t expected_events[$];
  bgc_pkg::sample_t on_bus;
  bgc_pkg::result_t head_event;
  logic [31:0] t_cur = '0;
  int unsigned items_queued = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bgc_pkg::result_t classify_sample(input bgc_pkg::sample_t s);
    bgc_pkg::result_t r;
    logic [31:0] held;
    logic [31:0] since;
    r = '0;
    if (s.button_down && !prev_down) begin
      press_t0 = s.now_ms;
      long_fired = 1'b0;
    end
    held = s.now_ms - press_t0;
    // a long press kills any single still waiting for its window
    if (s.button_down && !long_fired && held >= long_ms) begin
      long_fired = 1'b1;
      single_wait = 1'b0;
      r.go_to_sleep = 1'b1;
    end
    if (!s.button_down && prev_down) begin
      if (!long_fired && held >= min_ms && held < long_ms) begin
        if (s.alarm_overlay_active) begin
          r.stop_alarm = 1'b1;
        end else if (s.double_press_mode) begin
          since = s.now_ms - last_rel_t;
          if (since < window_ms) begin
            last_rel_t = '0;
            single_wait = 1'b0;
            r.toggle_fullscreen = 1'b1;
          end else begin
            last_rel_t = s.now_ms;
            single_wait = 1'b1;
            single_t0 = s.now_ms;
          end
        end else begin
          r.screen_toggles = r.screen_toggles + 2'd1;
        end
      end
    end
    since = s.now_ms - single_t0;
    if (single_wait && since >= window_ms) begin
      single_wait = 1'b0;
      r.screen_toggles = r.screen_toggles + 2'd1;
    end
    prev_down = s.button_down;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Sender: hold the beat until taken, then maybe idle
  always @(posedge clk_i) begin
    if (smp_if.valid && smp_if.ready)
      expected_events.push_back(classify_sample(on_bus));
    if (!smp_if.valid || smp_if.ready) begin
      if (pending_samples.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        on_bus = pending_samples.pop_front();
        smp_if.valid <= 1'b1;
        smp_if.button_down <= on_bus.button_down;
        smp_if.now_ms <= on_bus.now_ms;
        smp_if.alarm_overlay_active <= on_bus.alarm_overlay_active;
        smp_if.double_press_mode <= on_bus.double_press_mode;
      end else begin
        smp_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: compare each result beat against the oldest expected event
  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch("result beat with nothing expected", '0, '0);
      end else begin
        head_event = expected_events.pop_front();
        if (res_if.go_to_sleep !== head_event.go_to_sleep)
          report_mismatch("go_to_sleep", 32'(res_if.go_to_sleep),
                          32'(head_event.go_to_sleep));
        if (res_if.stop_alarm !== head_event.stop_alarm)
          report_mismatch("stop_alarm", 32'(res_if.stop_alarm),
                          32'(head_event.stop_alarm));
        if (res_if.toggle_fullscreen !== head_event.toggle_fullscreen)
          report_mismatch("toggle_fullscreen", 32'(res_if.toggle_fullscreen),
                          32'(head_event.toggle_fullscreen));
        if (res_if.screen_toggles !== head_event.screen_toggles)
          report_mismatch("screen_toggles", 32'(res_if.screen_toggles),
                          32'(head_event.screen_toggles));
      end
    end
    res_if.ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** button_gesture_classifier: FAILED **");
      $finish;
    end
  end

  task automatic push_at(input bit down, input logic [31:0] now, input bit alarm, dmode);
    bgc_pkg::sample_t s;
    s.button_down = down;
    s.now_ms = now;
    s.alarm_overlay_active = alarm;
    s.double_press_mode = dmode;
    pending_samples.push_back(s);
    items_queued++;
  endtask

  task automatic push_rel(input bit down, input int unsigned dt, input bit alarm, dmode);
    t_cur = t_cur + dt;
    push_at(down, t_cur, alarm, dmode);
  endtask

  function automatic int unsigned pick_short();
    int unsigned hi;
    if (long_ms <= min_ms) return $urandom_range(70000, 0);
    hi = long_ms - 1;
    // lean towards holds short enough for a second press to land in the window
    if ($urandom_range(9, 0) < 7 && min_ms + window_ms / 2 < hi) hi = min_ms + window_ms / 2;
    return $urandom_range(hi, min_ms);
  endfunction

  function automatic int unsigned pick_gap();
    case ($urandom_range(2, 0))
      0: return $urandom_range(window_ms, 0);
      1: return $urandom_range(2 * window_ms + 10, window_ms);
      default: return $urandom_range(200000, 0);
    endcase
  endfunction

  // One press: a down edge, up to four held samples, then the release
  task automatic add_press(input int unsigned gap, held, input bit alarm, dmode, linger);
    int unsigned sum;
    int unsigned d;
    int unsigned k;
    sum = 0;
    k = $urandom_range(3, 0);
    push_rel(1'b1, gap, alarm, dmode);
    for (int i = 0; i < k; i++) begin
      d = $urandom_range(held / 4, 0);
      sum += d;
      push_rel(1'b1, d, alarm, dmode);
    end
    if (linger) begin
      push_rel(1'b1, held - sum, alarm, dmode);
      push_rel(1'b0, $urandom_range(300, 0), alarm, dmode);
    end else begin
      push_rel(1'b0, held - sum, alarm, dmode ^ ($urandom_range(9, 0) == 0));
    end
  endtask

  task automatic add_random(input int unsigned n);
    int unsigned stop_at;
    int unsigned roll;
    bit alarm;
    bit dmode;
    stop_at = items_queued + n;
    while (items_queued < stop_at) begin
      roll = $urandom_range(99, 0);
      alarm = ($urandom_range(99, 0) < 15);
      dmode = ($urandom_range(99, 0) < 60);
      if (roll < 35) begin
        add_press(pick_gap(), pick_short(), alarm, dmode, 1'b0);
      end else if (roll < 50) begin
        add_press(pick_gap(), pick_short(), 1'b0, 1'b1, 1'b0);
        add_press($urandom_range(window_ms, 0), pick_short(), 1'b0, 1'b1, 1'b0);
      end else if (roll < 60) begin
        add_press(pick_gap(), long_ms + $urandom_range(400, 0), alarm, dmode, 1'b1);
      end else if (roll < 70) begin
        add_press(pick_gap(), (min_ms > 0) ? $urandom_range(min_ms - 1, 0) : 0,
                  alarm, dmode, 1'b0);
      end else if (roll < 85) begin
        repeat ($urandom_range(3, 1)) push_rel(1'b0, pick_gap(), alarm, dmode);
      end else begin
        repeat ($urandom_range(4, 1))
          push_at(1'($urandom_range(1, 0)), $urandom(), 1'($urandom_range(1, 0)),
                  1'($urandom_range(1, 0)));
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || expected_events.size() != 0 || smp_if.valid);
  endtask

  task automatic set_timings(input int unsigned lp, mp, dw);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= bgc_pkg::CFG_LONG_PRESS;
    cfg_wdata_i <= lp[15:0];
    @(posedge clk_i);
    cfg_idx_i <= bgc_pkg::CFG_MIN_PRESS;
    cfg_wdata_i <= mp[15:0];
    @(posedge clk_i);
    cfg_idx_i <= bgc_pkg::CFG_DOUBLE_WINDOW;
    cfg_wdata_i <= dw[15:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    long_ms = lp[15:0];
    min_ms = mp[15:0];
    window_ms = dw[15:0];
  endtask

  task automatic run_phase(input int unsigned send_pct, hold_pct, n);
    send_idle_pct = send_pct;
    stall_pct = hold_pct;
    t_cur = $urandom();
    add_random(n);
    drain();
  endtask

  task automatic add_directed();
    push_at(1'b0, 32'd0, 1'b0, 1'b0);
    // short release inside the window of time zero: double press
    push_at(1'b1, 32'd100, 1'b0, 1'b1);
    push_at(1'b0, 32'd200, 1'b0, 1'b1);
    // bounce below the minimum hold
    push_at(1'b1, 32'd1000, 1'b0, 1'b0);
    push_at(1'b0, 32'd1020, 1'b0, 1'b0);
    push_at(1'b1, 32'd2000, 1'b1, 1'b0);
    push_at(1'b0, 32'd2100, 1'b1, 1'b0);
    // deferred single, then an immediate toggle once the mode drops: two toggles
    push_at(1'b1, 32'd3000, 1'b0, 1'b1);
    push_at(1'b0, 32'd3100, 1'b0, 1'b1);
    push_at(1'b1, 32'd3110, 1'b0, 1'b0);
    push_at(1'b0, 32'd3500, 1'b0, 1'b0);
    push_at(1'b1, 32'd4000, 1'b0, 1'b1);
    push_at(1'b0, 32'd4100, 1'b0, 1'b1);
    push_at(1'b1, 32'd4200, 1'b0, 1'b1);
    push_at(1'b0, 32'd4300, 1'b0, 1'b1);
    // long press cancels a waiting single
    push_at(1'b1, 32'd5000, 1'b0, 1'b1);
    push_at(1'b0, 32'd5100, 1'b0, 1'b1);
    push_at(1'b1, 32'd5150, 1'b0, 1'b1);
    push_at(1'b1, 32'd8150, 1'b0, 1'b1);
    push_at(1'b1, 32'd9000, 1'b0, 1'b1);
    push_at(1'b0, 32'd9100, 1'b0, 1'b1);
    // hold across the timestamp wrap
    push_at(1'b1, 32'hFFFF_FF00, 1'b0, 1'b0);
    push_at(1'b0, 32'h0000_0010, 1'b0, 1'b0);
    push_at(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
    push_at(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1);
  endtask

  initial begin
    cfg_we_i = 1'b0;
    cfg_idx_i = bgc_pkg::CFG_LONG_PRESS;
    cfg_wdata_i = '0;
    smp_if.valid = 1'b0;
    smp_if.button_down = 1'b0;
    smp_if.now_ms = '0;
    smp_if.alarm_overlay_active = 1'b0;
    smp_if.double_press_mode = 1'b0;
    res_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_directed();
    run_phase(0, 0, 320);

    set_timings(1, 0, 1);
    run_phase(49, 0, 320);

    set_timings(65535, 65535, 65535);
    run_phase(0, 49, 320);

    set_timings($urandom_range(2000, 50), $urandom_range(40, 0), $urandom_range(500, 20));
    run_phase(23, 23, 320);

    set_timings(300, 0, 65535);
    run_phase(0, 0, 320);

    set_timings($urandom_range(65535, 1), $urandom_range(65535, 0),
                $urandom_range(65535, 1));
    run_phase(23, 23, 320);

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** button_gesture_classifier: PASSED **");
    end else begin
      $display("** button_gesture_classifier: FAILED **");
    end
    $finish;
  end

endmodule
